FILE: rtl/core/ulm_pkg.sv
package ulm_pkg;

  localparam int unsigned FIFO_DEPTH = 256;
  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  localparam int unsigned GUARD_W = 16;
  localparam int unsigned DEB_W = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [GUARD_W-1:0] GUARD_RESET = 16'd500;
  localparam logic [DEB_W-1:0] DEB_RESET = 4'd3;
  localparam logic [GUARD_W-1:0] QUIET_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_SAMPLE = 3'd1,
    REQ_BYTE   = 3'd2,
    REQ_POP    = 3'd3,
    REQ_TX     = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_CONN = 2'd1,
    EV_DISC = 2'd2
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GUARD    = 1'd0,
    CFG_DEBOUNCE = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    logic                step;
    logic [2:0]          req;
    logic                level;
    logic [GUARD_W-1:0]  guard;
    logic [DEB_W-1:0]    debounce;
  } link_req_t;

  typedef struct packed {
    logic   active;
    logic   link_up;
    event_e link_event;
  } link_stat_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] fifo_level(input logic [PTR_W-1:0] wr,
                                                  input logic [PTR_W-1:0] rd);
    if (wr >= rd) begin
      fifo_level = CNT_W'(wr) - CNT_W'(rd);
    end else begin
      fifo_level = CNT_W'(FIFO_DEPTH) - CNT_W'(rd) + CNT_W'(wr);
    end
  endfunction

endpackage

FILE: rtl/core/ulm_if.sv
interface ulm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] rx_byte;
  logic       line_level;

  modport source (output valid, output req_type, output rx_byte, output line_level,
                  input ready);
  modport sink (input valid, input req_type, input rx_byte, input line_level,
                output ready);
endinterface

interface ulm_out_if;
  logic       valid;
  logic       ready;
  logic       link_up;
  logic [1:0] link_event;
  logic       pop_valid;
  logic [7:0] pop_byte;
  logic [7:0] fifo_count;
  logic       byte_dropped;

  modport source (output valid, output link_up, output link_event, output pop_valid,
                  output pop_byte, output fifo_count, output byte_dropped,
                  input ready);
  modport sink (input valid, input link_up, input link_event, input pop_valid,
                input pop_byte, input fifo_count, input byte_dropped,
                output ready);
endinterface

FILE: rtl/core/uart_link_monitor_rx_fifo.sv
// throughput: one item per cycle while the result side keeps taking transfers
// an input register and a result register bound one pass of counter and pointer logic
// reset clears the link state, quiet timer, debounce counters and buffer pointers,
// and loads guard_ms 500 and debounce_count 3; buffer contents stay undefined
module uart_link_monitor_rx_fifo (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ulm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ulm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  ulm_in_if.sink                           in_ch,
  ulm_out_if.source                        out_ch
);

  logic [ulm_pkg::GUARD_W-1:0] guard_q;
  logic [ulm_pkg::DEB_W-1:0]   deb_q;

  logic                        v1_q;
  logic [2:0]                  req1_q;
  logic [7:0]                  byte1_q;
  logic                        lvl1_q;

  logic                        v2_q;
  logic                        link_up_q;
  ulm_pkg::event_e             event_q;
  logic                        pvalid_q;
  logic [7:0]                  rdata_q;
  logic [7:0]                  count_q;
  logic                        dropped_q;

  logic [ulm_pkg::PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [7:0]                  mem [ulm_pkg::FIFO_DEPTH];

  logic                        adv2, adv1, in_xfer;
  logic                        do_write, do_pop, dropped_d;
  ulm_pkg::link_req_t          link_req;
  ulm_pkg::link_stat_t         link_stat;

  assign adv2    = !v2_q || out_ch.ready;
  assign adv1    = v1_q && adv2;
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !v1_q || adv2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guard_q <= ulm_pkg::GUARD_RESET;
      deb_q   <= ulm_pkg::DEB_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ulm_pkg::CFG_GUARD:    guard_q <= cfg_wdata_i[ulm_pkg::GUARD_W-1:0];
        ulm_pkg::CFG_DEBOUNCE: deb_q   <= cfg_wdata_i[ulm_pkg::DEB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign link_req.step     = adv1;
  assign link_req.req      = req1_q;
  assign link_req.level    = lvl1_q;
  assign link_req.guard    = guard_q;
  assign link_req.debounce = deb_q;

  ulm_link u_link (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (link_req),
    .stat_o (link_stat)
  );

  always_comb begin
    wr_d      = wr_q;
    rd_d      = rd_q;
    do_write  = 1'b0;
    do_pop    = 1'b0;
    dropped_d = 1'b0;
    case (req1_q)
      ulm_pkg::REQ_BYTE: begin
        if (link_stat.active && ulm_pkg::ptr_next(wr_q) != rd_q) begin
          do_write = 1'b1;
          wr_d     = ulm_pkg::ptr_next(wr_q);
        end else begin
          dropped_d = 1'b1;
        end
      end
      ulm_pkg::REQ_POP: begin
        if (rd_q != wr_q) begin
          do_pop = 1'b1;
          rd_d   = ulm_pkg::ptr_next(rd_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (in_xfer) begin
        v1_q <= 1'b1;
      end else if (adv1) begin
        v1_q <= 1'b0;
      end
      if (adv2) v2_q <= adv1;
      if (adv1) begin
        wr_q <= wr_d;
        rd_q <= rd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req1_q  <= in_ch.req_type;
      byte1_q <= in_ch.rx_byte;
      lvl1_q  <= in_ch.line_level;
    end
    if (adv1) begin
      link_up_q <= link_stat.link_up;
      event_q   <= link_stat.link_event;
      pvalid_q  <= do_pop;
      count_q   <= 8'(ulm_pkg::fifo_level(wr_d, rd_d));
      dropped_q <= dropped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && do_write) mem[wr_q] <= byte1_q;
    if (adv1 && do_pop) rdata_q <= mem[rd_q];
  end

  assign out_ch.valid        = v2_q;
  assign out_ch.link_up      = link_up_q;
  assign out_ch.link_event   = event_q;
  assign out_ch.pop_valid    = pvalid_q;
  assign out_ch.pop_byte     = pvalid_q ? rdata_q : 8'd0;
  assign out_ch.fifo_count   = count_q;
  assign out_ch.byte_dropped = dropped_q;

endmodule

FILE: rtl/core/ulm_link.sv
module ulm_link (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ulm_pkg::link_req_t req_i,
  output ulm_pkg::link_stat_t stat_o
);

  logic                        active_q, active_d;
  logic [ulm_pkg::GUARD_W-1:0] quiet_q, quiet_d;
  logic [ulm_pkg::DEB_W-1:0]   low_q, low_d;
  logic [ulm_pkg::DEB_W-1:0]   high_q, high_d;
  logic [ulm_pkg::DEB_W-1:0]   low_inc, high_inc;
  ulm_pkg::event_e             event_d;

  assign low_inc  = low_q + ulm_pkg::DEB_W'(1);
  assign high_inc = high_q + ulm_pkg::DEB_W'(1);

  always_comb begin
    active_d = active_q;
    quiet_d  = quiet_q;
    low_d    = low_q;
    high_d   = high_q;
    event_d  = ulm_pkg::EV_NONE;
    case (req_i.req)
      ulm_pkg::REQ_TICK: begin
        if (quiet_q != ulm_pkg::QUIET_MAX) quiet_d = quiet_q + ulm_pkg::GUARD_W'(1);
      end
      ulm_pkg::REQ_SAMPLE: begin
        if (active_q) begin
          if (quiet_q < req_i.guard || req_i.level) begin
            low_d = '0;
          end else if (low_inc >= req_i.debounce) begin
            low_d    = '0;
            active_d = 1'b0;
            event_d  = ulm_pkg::EV_DISC;
          end else begin
            low_d = low_inc;
          end
        end else if (req_i.level) begin
          if (high_inc >= req_i.debounce) begin
            high_d   = '0;
            low_d    = '0;
            quiet_d  = '0;
            active_d = 1'b1;
            event_d  = ulm_pkg::EV_CONN;
          end else begin
            high_d = high_inc;
          end
        end else begin
          high_d = '0;
        end
      end
      ulm_pkg::REQ_BYTE, ulm_pkg::REQ_TX: begin
        if (active_q) quiet_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      quiet_q  <= '0;
      low_q    <= '0;
      high_q   <= '0;
    end else if (req_i.step) begin
      active_q <= active_d;
      quiet_q  <= quiet_d;
      low_q    <= low_d;
      high_q   <= high_d;
    end
  end

  assign stat_o.active     = active_q;
  assign stat_o.link_up    = active_d;
  assign stat_o.link_event = event_d;

endmodule
